// ===== src/prfs_pkg.sv =====
// Shared types and constants for the pair rest-frame separation block.
// No dependencies; imported by the divide/sqrt unit and the top level.
package prfs_pkg;

    typedef enum logic {
        DU_DIV  = 1'b0,
        DU_SQRT = 1'b1
    } du_op_t;

    // command word from the sequencer to the divide/sqrt unit
    typedef struct packed {
        logic   start;
        du_op_t op;
    } du_ctrl_t;

    localparam logic [127:0] SMALL_PROD_LIMIT = 128'd42949672;
    localparam logic [63:0]  COS_TOL_NUM      = 64'd10000000;
    localparam logic [63:0]  COS_TOL_DEN      = 64'd10000001;
    localparam logic [63:0]  COS_MAG_SAT      = 64'h7FFF_FFFF_FFFF_FFFF;
    localparam logic [14:0]  COS_ONE          = 15'd16384;

    // accumulator slots
    localparam logic [2:0] ACC_NN = 3'd0;
    localparam logic [2:0] ACC_NK = 3'd1;
    localparam logic [2:0] ACC_NS = 3'd2;
    localparam logic [2:0] ACC_KK = 3'd3;
    localparam logic [2:0] ACC_SS = 3'd4;
    localparam logic [2:0] ACC_SK = 3'd5;
    localparam int         ACC_COUNT = 6;

endpackage

// ===== src/prfs_if.sv =====
// Valid/ready channel interfaces for input items and result words.
// No dependencies.
interface prfs_item_if;
    logic               valid;
    logic               ready;
    logic signed [31:0] first_momentum;
    logic signed [31:0] second_momentum;
    logic signed [31:0] first_position;
    logic signed [31:0] second_position;
    logic signed [15:0] random_cosine;

    modport source (output valid, first_momentum, second_momentum, first_position,
                    second_position, random_cosine, input ready);
    modport sink   (input valid, first_momentum, second_momentum, first_position,
                    second_position, random_cosine, output ready);
endinterface

interface prfs_result_if;
    logic               valid;
    logic               ready;
    logic        [31:0] rel_momentum;
    logic        [31:0] separation;
    logic signed [15:0] cos_angle;
    logic               error;

    modport source (output valid, rel_momentum, separation, cos_angle, error, input ready);
    modport sink   (input valid, rel_momentum, separation, cos_angle, error, output ready);
endinterface

// ===== src/prfs_divsqrt.sv =====
// Bit-serial unit: 128/64 restoring divide or 128-bit floor sqrt.
// Depends on prfs_pkg.
module prfs_divsqrt (
    input  logic               clk,
    input  logic               rst_n,
    input  prfs_pkg::du_ctrl_t ctrl,
    input  logic [127:0]       x,
    input  logic [63:0]        den,
    output logic               done,
    output logic [127:0]       res
);
    import prfs_pkg::*;

    logic         run_reg;
    logic         done_reg;
    du_op_t       op_reg;
    logic [6:0]   cnt_reg;
    logic [127:0] x_reg;
    logic [65:0]  rem_reg;
    logic [63:0]  root_reg;
    logic [63:0]  den_reg;

    logic [64:0]  div_rd;
    logic         div_ge;
    logic [67:0]  sq_rs;
    logic [67:0]  sq_trial;
    logic         sq_ge;

    always_comb
    begin
        div_rd   = {rem_reg[63:0], x_reg[127]};
        div_ge   = div_rd >= {1'b0, den_reg};
        sq_rs    = {rem_reg, x_reg[127:126]};
        sq_trial = {2'b00, root_reg, 2'b01};
        sq_ge    = sq_rs >= sq_trial;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            run_reg  <= 1'b0;
            done_reg <= 1'b0;
            op_reg   <= DU_DIV;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (ctrl.start)
            begin
                run_reg  <= 1'b1;
                op_reg   <= ctrl.op;
                cnt_reg  <= (ctrl.op == DU_SQRT) ? 7'd63 : 7'd127;
                x_reg    <= x;
                den_reg  <= den;
                rem_reg  <= '0;
                root_reg <= '0;
            end
            else if (run_reg)
            begin
                case (op_reg)
                    DU_DIV:
                    begin
                        rem_reg <= {1'b0, div_ge ? (div_rd - {1'b0, den_reg}) : div_rd};
                        x_reg   <= {x_reg[126:0], div_ge};
                    end
                    DU_SQRT:
                    begin
                        rem_reg  <= sq_ge ? 66'(sq_rs - sq_trial) : sq_rs[65:0];
                        root_reg <= {root_reg[62:0], sq_ge};
                        x_reg    <= {x_reg[125:0], 2'b00};
                    end
                    default:
                    begin
                        rem_reg <= rem_reg;
                    end
                endcase
                cnt_reg <= cnt_reg - 7'd1;
                if (cnt_reg == 7'd0)
                begin
                    run_reg  <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    assign done = done_reg;
    assign res  = (op_reg == DU_SQRT) ? {64'b0, root_reg} : x_reg;

endmodule

// ===== src/pair_rest_frame_separation_core.sv =====
// Pair rest-frame separation (qinv) core.
// Takes one four-vector component of both particles per input word, time first,
// then x, y, z, and accumulates six Minkowski products (metric +,-,-,-).
// After the fourth component it projects the relative momentum and separation
// orthogonal to the pair momentum and returns one result word: q, r, the cosine
// between them and an error flag (payload zero on error).
// Channels: item (sink) and result (source), valid/ready, a word moves when both
// are high. Each component runs six 64x64 products through one 32x32 multiplier,
// four partial products each. The fourth component then uses the bit-serial
// divide/sqrt unit for three divides and three square roots, and six more products.
// A cosine divide follows, skipped when q*r is small.
// item.ready is high only while idle. The result sits in an output register; the
// next group of components is taken while it waits. If a new result is finished
// while the previous one is still unread, the core holds until it is taken.
// Reset clears the component count, the accumulators and the result valid.
// Depends on prfs_pkg, prfs_if and prfs_divsqrt.
module pair_rest_frame_separation_core (
    input  logic                 clk,
    input  logic                 rst_n,
    prfs_item_if.sink            item,
    prfs_result_if.source        result
);
    import prfs_pkg::*;

    typedef enum logic [4:0] {
        ST_IDLE, ST_ACC_SET, ST_MUL, ST_ACC_ADD, ST_DU_WAIT,
        ST_F_CHK, ST_F_QDIV, ST_F_QSUB, ST_F_RDIV, ST_F_RSUB, ST_F_CDIV, ST_F_CSUB,
        ST_F_PSQRT, ST_F_AMUL, ST_F_BMUL, ST_F_CMP, ST_F_QS, ST_F_RS, ST_F_COS,
        ST_ERR, ST_DONE
    } state_t;

    typedef struct packed {
        logic         neg;
        logic [127:0] mag;
    } sm_t;

    state_t       state_reg;
    state_t       ret_reg;
    logic [1:0]   cnt_reg;
    logic [2:0]   prod_idx_reg;
    logic [1:0]   part_reg;
    logic [63:0]  m_a_reg;
    logic [63:0]  m_b_reg;
    logic [127:0] prod_reg;
    logic         neg_reg;
    logic [32:0]  n_reg;
    logic [32:0]  d_reg;
    logic [32:0]  s_reg;
    logic [15:0]  rnd_reg;
    logic [63:0]  acc_reg [ACC_COUNT];
    du_ctrl_t     du_ctrl_reg;
    logic [127:0] du_x_reg;
    logic [63:0]  du_den_reg;
    logic [63:0]  q2u_reg;
    logic [63:0]  r2u_reg;
    logic         q2_neg_reg;
    logic [63:0]  ctm_reg;
    logic         ct_neg_reg;
    logic [127:0] p_reg;
    logic [63:0]  s_root_reg;
    logic [127:0] a_cmp_reg;
    logic [31:0]  qo_reg;
    logic [31:0]  ro_reg;
    logic [15:0]  co_reg;
    logic         err_reg;
    logic         out_valid_reg;
    logic [31:0]  rel_momentum_reg;
    logic [31:0]  separation_reg;
    logic [15:0]  cos_angle_reg;
    logic         error_reg;

    logic         du_done;
    logic [127:0] du_res;

    logic [31:0]  a_part;
    logic [31:0]  b_part;
    logic [63:0]  pp;
    logic [127:0] pp_sh;
    logic [32:0]  n_abs;
    logic [32:0]  d_abs;
    logic [32:0]  s_abs;
    logic [32:0]  op_a;
    logic [32:0]  op_b;
    logic         op_neg;
    logic [63:0]  shr;
    logic [63:0]  term;
    logic [63:0]  acc_sel;
    sm_t          sm_a;
    sm_t          sm_b;
    sm_t          sm_res;
    logic [14:0]  cos_mag;
    logic [15:0]  cos_val;
    logic [15:0]  rnd_clamped;

    function automatic logic [63:0] abs64(input logic [63:0] v);
        abs64 = v[63] ? (~v + 64'd1) : v;
    endfunction

    function automatic sm_t scale8(input logic [63:0] v);
        sm_t r;
        r.neg = v[63];
        r.mag = {56'b0, abs64(v), 8'b0};
        return r;
    endfunction

    // a - b, sign-magnitude; zero is never negative
    function automatic sm_t smsub(input sm_t a, input sm_t b);
        sm_t  r;
        logic bn;
        bn = !b.neg;
        if (a.neg == bn)
        begin
            r.neg = a.neg;
            r.mag = a.mag + b.mag;
        end
        else if (a.mag >= b.mag)
        begin
            r.neg = a.neg;
            r.mag = a.mag - b.mag;
        end
        else
        begin
            r.neg = bn;
            r.mag = b.mag - a.mag;
        end
        if (r.mag == '0)
        begin
            r.neg = 1'b0;
        end
        return r;
    endfunction

    prfs_divsqrt u_divsqrt (
        .clk  (clk),
        .rst_n(rst_n),
        .ctrl (du_ctrl_reg),
        .x    (du_x_reg),
        .den  (du_den_reg),
        .done (du_done),
        .res  (du_res)
    );

    // shared 32x32 multiplier, one partial product per cycle
    always_comb
    begin
        a_part = part_reg[1] ? m_a_reg[63:32] : m_a_reg[31:0];
        b_part = part_reg[0] ? m_b_reg[63:32] : m_b_reg[31:0];
        pp     = a_part * b_part;
        case (part_reg)
            2'b00:   pp_sh = {64'b0, pp};
            2'b11:   pp_sh = {pp, 64'b0};
            default: pp_sh = {32'b0, pp, 32'b0};
        endcase
    end

    always_comb
    begin
        n_abs = n_reg[32] ? (~n_reg + 33'd1) : n_reg;
        d_abs = d_reg[32] ? (~d_reg + 33'd1) : d_reg;
        s_abs = s_reg[32] ? (~s_reg + 33'd1) : s_reg;
        case (prod_idx_reg)
            ACC_NN:  begin op_a = n_abs; op_b = n_abs; op_neg = 1'b0;                end
            ACC_NK:  begin op_a = n_abs; op_b = d_abs; op_neg = n_reg[32] ^ d_reg[32]; end
            ACC_NS:  begin op_a = n_abs; op_b = s_abs; op_neg = n_reg[32] ^ s_reg[32]; end
            ACC_KK:  begin op_a = d_abs; op_b = d_abs; op_neg = 1'b0;                end
            ACC_SS:  begin op_a = s_abs; op_b = s_abs; op_neg = 1'b0;                end
            default: begin op_a = s_abs; op_b = d_abs; op_neg = s_reg[32] ^ d_reg[32]; end
        endcase
        // k = (p1-p2)/2 folds into one extra shift per factor of d
        case (prod_idx_reg)
            ACC_NK, ACC_SK: shr = prod_reg[72:9];
            ACC_KK:         shr = prod_reg[73:10];
            default:        shr = prod_reg[71:8];
        endcase
        term    = neg_reg ? (~shr + 64'd1) : shr;
        acc_sel = acc_reg[prod_idx_reg];
    end

    always_comb
    begin
        sm_a.neg = 1'b0;
        sm_a.mag = du_res;
        case (state_reg)
            ST_F_QSUB: sm_b = scale8(acc_reg[ACC_KK]);
            ST_F_RSUB: sm_b = scale8(acc_reg[ACC_SS]);
            default:
            begin
                sm_b     = scale8(acc_reg[ACC_SK]);
                sm_a.neg = (acc_reg[ACC_NK][63] ^ acc_reg[ACC_NS][63]) && (du_res != '0);
            end
        endcase
        sm_res = smsub(sm_a, sm_b);
    end

    always_comb
    begin
        if (du_res[127:15] != '0 || du_res[14:0] > COS_ONE)
        begin
            cos_mag = COS_ONE;
        end
        else
        begin
            cos_mag = du_res[14:0];
        end
        cos_val = ct_neg_reg ? (~{1'b0, cos_mag} + 16'd1) : {1'b0, cos_mag};
        if ($signed(rnd_reg) > $signed({1'b0, COS_ONE}))
        begin
            rnd_clamped = {1'b0, COS_ONE};
        end
        else if ($signed(rnd_reg) < -$signed({1'b0, COS_ONE}))
        begin
            rnd_clamped = ~{1'b0, COS_ONE} + 16'd1;
        end
        else
        begin
            rnd_clamped = rnd_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            ret_reg       <= ST_IDLE;
            cnt_reg       <= '0;
            prod_idx_reg  <= '0;
            part_reg      <= '0;
            du_ctrl_reg   <= '{start: 1'b0, op: DU_DIV};
            out_valid_reg <= 1'b0;
            for (int i = 0; i < ACC_COUNT; i++)
            begin
                acc_reg[i] <= '0;
            end
        end
        else
        begin
            du_ctrl_reg.start <= 1'b0;
            // ST_DONE reloads the output word itself when the receiver takes it
            if (result.ready && state_reg != ST_DONE)
            begin
                out_valid_reg <= 1'b0;
            end
            case (state_reg)
                ST_IDLE:
                begin
                    if (item.valid)
                    begin
                        n_reg <= {item.first_momentum[31], item.first_momentum}
                               + {item.second_momentum[31], item.second_momentum};
                        d_reg <= {item.first_momentum[31], item.first_momentum}
                               - {item.second_momentum[31], item.second_momentum};
                        s_reg <= {item.first_position[31], item.first_position}
                               - {item.second_position[31], item.second_position};
                        rnd_reg      <= item.random_cosine;
                        prod_idx_reg <= '0;
                        state_reg    <= ST_ACC_SET;
                    end
                end
                ST_ACC_SET:
                begin
                    m_a_reg   <= {31'b0, op_a};
                    m_b_reg   <= {31'b0, op_b};
                    neg_reg   <= op_neg;
                    prod_reg  <= '0;
                    part_reg  <= '0;
                    ret_reg   <= ST_ACC_ADD;
                    state_reg <= ST_MUL;
                end
                ST_MUL:
                begin
                    prod_reg <= prod_reg + pp_sh;
                    part_reg <= part_reg + 2'd1;
                    if (part_reg == 2'b11)
                    begin
                        state_reg <= ret_reg;
                    end
                end
                ST_ACC_ADD:
                begin
                    // time component adds, spatial ones subtract
                    acc_reg[prod_idx_reg] <= (cnt_reg == 2'd0) ? acc_sel + term
                                                               : acc_sel - term;
                    if (prod_idx_reg == ACC_SK)
                    begin
                        prod_idx_reg <= '0;
                        if (cnt_reg == 2'd3)
                        begin
                            state_reg <= ST_F_CHK;
                        end
                        else
                        begin
                            cnt_reg   <= cnt_reg + 2'd1;
                            state_reg <= ST_IDLE;
                        end
                    end
                    else
                    begin
                        prod_idx_reg <= prod_idx_reg + 3'd1;
                        state_reg    <= ST_ACC_SET;
                    end
                end
                ST_DU_WAIT:
                begin
                    if (du_done)
                    begin
                        state_reg <= ret_reg;
                    end
                end
                ST_F_CHK:
                begin
                    if (acc_reg[ACC_NN][63] || acc_reg[ACC_NN] == '0)
                    begin
                        state_reg <= ST_ERR;
                    end
                    else
                    begin
                        m_a_reg   <= abs64(acc_reg[ACC_NK]);
                        m_b_reg   <= abs64(acc_reg[ACC_NK]);
                        prod_reg  <= '0;
                        part_reg  <= '0;
                        ret_reg   <= ST_F_QDIV;
                        state_reg <= ST_MUL;
                    end
                end
                ST_F_QDIV, ST_F_RDIV, ST_F_CDIV:
                begin
                    du_ctrl_reg <= '{start: 1'b1, op: DU_DIV};
                    du_x_reg    <= {prod_reg[119:0], 8'b0};
                    du_den_reg  <= acc_reg[ACC_NN];
                    case (state_reg)
                        ST_F_QDIV: ret_reg <= ST_F_QSUB;
                        ST_F_RDIV: ret_reg <= ST_F_RSUB;
                        default:   ret_reg <= ST_F_CSUB;
                    endcase
                    state_reg <= ST_DU_WAIT;
                end
                ST_F_QSUB:
                begin
                    q2_neg_reg <= sm_res.neg;
                    q2u_reg    <= (sm_res.mag[127:64] != '0) ? '1 : sm_res.mag[63:0];
                    m_a_reg    <= abs64(acc_reg[ACC_NS]);
                    m_b_reg    <= abs64(acc_reg[ACC_NS]);
                    prod_reg   <= '0;
                    part_reg   <= '0;
                    ret_reg    <= ST_F_RDIV;
                    state_reg  <= ST_MUL;
                end
                ST_F_RSUB:
                begin
                    r2u_reg <= (sm_res.mag[127:64] != '0) ? '1 : sm_res.mag[63:0];
                    if (q2_neg_reg || sm_res.neg)
                    begin
                        state_reg <= ST_ERR;
                    end
                    else
                    begin
                        m_a_reg   <= abs64(acc_reg[ACC_NK]);
                        m_b_reg   <= abs64(acc_reg[ACC_NS]);
                        prod_reg  <= '0;
                        part_reg  <= '0;
                        ret_reg   <= ST_F_CDIV;
                        state_reg <= ST_MUL;
                    end
                end
                ST_F_CSUB:
                begin
                    ct_neg_reg <= sm_res.neg;
                    ctm_reg    <= (sm_res.mag[127:64] != '0 || sm_res.mag[63])
                                  ? COS_MAG_SAT : sm_res.mag[63:0];
                    m_a_reg    <= q2u_reg;
                    m_b_reg    <= r2u_reg;
                    prod_reg   <= '0;
                    part_reg   <= '0;
                    ret_reg    <= ST_F_PSQRT;
                    state_reg  <= ST_MUL;
                end
                ST_F_PSQRT:
                begin
                    p_reg       <= prod_reg;
                    du_ctrl_reg <= '{start: 1'b1, op: DU_SQRT};
                    du_x_reg    <= prod_reg;
                    ret_reg     <= ST_F_AMUL;
                    state_reg   <= ST_DU_WAIT;
                end
                ST_F_AMUL:
                begin
                    s_root_reg <= du_res[63:0];
                    m_a_reg    <= ctm_reg;
                    m_b_reg    <= COS_TOL_NUM;
                    prod_reg   <= '0;
                    part_reg   <= '0;
                    ret_reg    <= ST_F_BMUL;
                    state_reg  <= ST_MUL;
                end
                ST_F_BMUL:
                begin
                    a_cmp_reg <= prod_reg;
                    m_a_reg   <= s_root_reg;
                    m_b_reg   <= COS_TOL_DEN;
                    prod_reg  <= '0;
                    part_reg  <= '0;
                    ret_reg   <= ST_F_CMP;
                    state_reg <= ST_MUL;
                end
                ST_F_CMP:
                begin
                    if (a_cmp_reg > prod_reg)
                    begin
                        state_reg <= ST_ERR;
                    end
                    else
                    begin
                        du_ctrl_reg <= '{start: 1'b1, op: DU_SQRT};
                        du_x_reg    <= {64'b0, q2u_reg};
                        ret_reg     <= ST_F_QS;
                        state_reg   <= ST_DU_WAIT;
                    end
                end
                ST_F_QS:
                begin
                    qo_reg      <= du_res[31:0];
                    du_ctrl_reg <= '{start: 1'b1, op: DU_SQRT};
                    du_x_reg    <= {64'b0, r2u_reg};
                    ret_reg     <= ST_F_RS;
                    state_reg   <= ST_DU_WAIT;
                end
                ST_F_RS:
                begin
                    ro_reg  <= du_res[31:0];
                    err_reg <= 1'b0;
                    if (p_reg > SMALL_PROD_LIMIT)
                    begin
                        du_ctrl_reg <= '{start: 1'b1, op: DU_DIV};
                        du_x_reg    <= {50'b0, ctm_reg, 14'b0};
                        du_den_reg  <= s_root_reg;
                        ret_reg     <= ST_F_COS;
                        state_reg   <= ST_DU_WAIT;
                    end
                    else
                    begin
                        co_reg    <= rnd_clamped;
                        state_reg <= ST_DONE;
                    end
                end
                ST_F_COS:
                begin
                    co_reg    <= cos_val;
                    state_reg <= ST_DONE;
                end
                ST_ERR:
                begin
                    qo_reg    <= '0;
                    ro_reg    <= '0;
                    co_reg    <= '0;
                    err_reg   <= 1'b1;
                    state_reg <= ST_DONE;
                end
                ST_DONE:
                begin
                    if (!out_valid_reg || result.ready)
                    begin
                        rel_momentum_reg <= qo_reg;
                        separation_reg   <= ro_reg;
                        cos_angle_reg    <= co_reg;
                        error_reg        <= err_reg;
                        out_valid_reg    <= 1'b1;
                        cnt_reg          <= '0;
                        for (int i = 0; i < ACC_COUNT; i++)
                        begin
                            acc_reg[i] <= '0;
                        end
                        state_reg <= ST_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

    assign item.ready          = (state_reg == ST_IDLE);
    assign result.valid        = out_valid_reg;
    assign result.rel_momentum = rel_momentum_reg;
    assign result.separation   = separation_reg;
    assign result.cos_angle    = cos_angle_reg;
    assign result.error        = error_reg;

    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        item.valid && item.ready |=> !item.ready)
        else $error("core took a second word without finishing the first");

    a_error_zero_payload: assert property (@(posedge clk) disable iff (!rst_n)
        result.valid && result.error |->
            result.rel_momentum == '0 && result.separation == '0 && result.cos_angle == '0)
        else $error("error result carries nonzero payload");

    a_cos_range: assert property (@(posedge clk) disable iff (!rst_n)
        result.valid |-> $signed(result.cos_angle) <= 16'sd16384 &&
                         $signed(result.cos_angle) >= -16'sd16384)
        else $error("cosine out of range");

    a_du_idle_on_start: assert property (@(posedge clk) disable iff (!rst_n)
        du_ctrl_reg.start |-> state_reg == ST_DU_WAIT)
        else $error("divide/sqrt started outside its wait state");

endmodule
